@@ rtl/cdb_pkg.sv @@
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared constants, operation and status codes, and the types that run
// between the deque control engine and the top level.
// ----------------------------------------------------------------------------
package cdb_pkg;

	localparam int DEPTH      = 1024;
	localparam int DATA_WIDTH = 32;

	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDX_W   = 10;
	localparam int KIND_W  = 3;
	localparam int VAL_W   = 32;
	localparam int OCNT_W  = 11;
	localparam int CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;

	typedef enum logic [KIND_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_BACK   = 3'd2,
		OP_POP_FRONT  = 3'd3,
		OP_CLEAR      = 3'd4,
		OP_READ       = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// one access to the entry store per beat: a write or a read, never both
	typedef struct packed {
		logic                  we;
		logic [PTR_W-1:0]      waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [PTR_W-1:0]      raddr;
	} mem_req_t;

	// result of one operation, presented in the cycle after acceptance
	typedef struct packed {
		logic              done;
		logic              hit;
		logic [OCNT_W-1:0] count;
		status_t           status;
	} rsp_t;

endpackage

@@ rtl/cdb_ram.sv @@
// ----------------------------------------------------------------------------
// cdb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/cdb_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdb_ctrl
// Pointer and count engine of the deque: checks each operation, moves the
// head and tail pointers, issues the store access and registers the result.
// ----------------------------------------------------------------------------
module cdb_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [cdb_pkg::KIND_W-1:0]     kind,
	input  logic [cdb_pkg::VAL_W-1:0]      value,
	input  logic [cdb_pkg::IDX_W-1:0]      index,
	output cdb_pkg::mem_req_t              mem_req,
	output cdb_pkg::rsp_t                  rsp_s1
);

	import cdb_pkg::*;

	logic [PTR_W-1:0] head_q, head_d;
	logic [PTR_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0] cnt_q,  cnt_d;
	status_t          status_d;
	logic             hit_d;

	logic             full, empty, in_range;
	logic [PTR_W:0]   rd_sum;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W-1:0] head_prev, tail_next, tail_prev, head_next;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign in_range = (CMP_W'(index) < CMP_W'(cnt_q));

	assign head_prev = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - 1'b1;
	assign head_next = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? PTR_W'(DEPTH - 1) : tail_q - 1'b1;
	assign tail_next = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// offset stays below the count on a valid read, so one subtract wraps it
	assign rd_sum  = {1'b0, head_q} + {1'b0, PTR_W'(index)};
	assign rd_addr = (rd_sum >= (PTR_W+1)'(DEPTH)) ? PTR_W'(rd_sum - (PTR_W+1)'(DEPTH))
	                                               : PTR_W'(rd_sum);

	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		cnt_d         = cnt_q;
		status_d      = ST_OK;
		hit_d         = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = tail_q;
		mem_req.wdata = DATA_WIDTH'($unsigned(value));
		mem_req.re    = 1'b0;
		mem_req.raddr = rd_addr;
		if (accept) begin
			case (kind)
				OP_PUSH_BACK: begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						mem_req.we = 1'b1;
						tail_d     = tail_next;
						cnt_d      = cnt_q + 1'b1;
					end
				end
				OP_PUSH_FRONT: begin
					mem_req.waddr = head_prev;
					if (full) begin
						status_d = ST_FULL;
					end else begin
						mem_req.we = 1'b1;
						head_d     = head_prev;
						cnt_d      = cnt_q + 1'b1;
					end
				end
				OP_POP_BACK: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						tail_d = tail_prev;
						cnt_d  = cnt_q - 1'b1;
					end
				end
				OP_POP_FRONT: begin
					if (empty) begin
						status_d = ST_EMPTY;
					end else begin
						head_d = head_next;
						cnt_d  = cnt_q - 1'b1;
					end
				end
				OP_CLEAR: begin
					head_d = '0;
					tail_d = '0;
					cnt_d  = '0;
				end
				OP_READ: begin
					if (in_range) begin
						mem_req.re = 1'b1;
						hit_d      = 1'b1;
					end else begin
						status_d = ST_RANGE;
					end
				end
				default: begin
					// unused codes: no operation
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			rsp_s1 <= '0;
		end else begin
			head_q         <= head_d;
			tail_q         <= tail_d;
			cnt_q          <= cnt_d;
			rsp_s1.done    <= accept;
			rsp_s1.hit     <= hit_d;
			rsp_s1.count   <= OCNT_W'(cnt_d);
			rsp_s1.status  <= status_d;
		end
	end

endmodule

@@ rtl/circular_deque_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// circular_deque_buffer_unit
// Double-ended queue held in a circular entry store with head/tail pointers.
// ----------------------------------------------------------------------------
// Usage:
//   Drive kind, value and index with start high; the beat is taken at any
//   clock edge where start is high and busy is low. busy stays low: every
//   operation is taken in its own cycle, one per clock.
//   kind selects push back, push front, pop back, pop front, clear or read
//   (the entry at offset index from the front).
//   Exactly one result follows each beat of any kind, in the next cycle, on
//   read_value, count and status, marked by done for a single cycle.
//   Throughput is one operation per cycle, set by the one write port and
//   one read port of the entry store and its registered read.
//   read_value is zero except on a successful read. A pop on an empty queue,
//   a read at or past the count and a push while full change nothing and
//   report a status code.
//   Reset clears the pointers, the count and done; the entry store is not
//   cleared and needs no pass, since only entries written by a push are
//   read. The receiver cannot stall: results are not held.
// ----------------------------------------------------------------------------
module circular_deque_buffer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic        [cdb_pkg::KIND_W-1:0] kind,
	input  logic signed [cdb_pkg::VAL_W-1:0]  value,
	input  logic        [cdb_pkg::IDX_W-1:0]  index,
	output logic                              done,
	output logic signed [cdb_pkg::VAL_W-1:0]  read_value,
	output logic        [cdb_pkg::OCNT_W-1:0] count,
	output logic        [1:0]                 status
);

	import cdb_pkg::*;

	mem_req_t              mem_req;
	rsp_t                  rsp_s1;
	logic [DATA_WIDTH-1:0] rdata;
	logic                  accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	cdb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.kind    (kind),
		.value   ($unsigned(value)),
		.index   (index),
		.mem_req (mem_req),
		.rsp_s1  (rsp_s1)
	);

	cdb_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	assign done       = rsp_s1.done;
	assign count      = rsp_s1.count;
	assign status     = rsp_s1.status;
	assign read_value = rsp_s1.hit ? $signed(VAL_W'(rdata)) : '0;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted beat produced no result");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without an accepted beat");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (count <= OCNT_W'(DEPTH)))
		else $error("count past depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (read_value == '0))
		else $error("nonzero read value on error");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (count == '0))
		else $error("empty status with nonzero count");

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: circular deque buffer regression
// Drives deque operations through the start/busy command port with random
// sender gaps. A local deque model predicts read value, count and status for
// each accepted beat. A checker compares every done beat against the oldest
// prediction in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdb_pkg::*;

	localparam logic [KIND_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int RESET_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_OPS   = 700;

	typedef struct {
		logic signed [VAL_W-1:0] read_value;
		logic [OCNT_W-1:0]       count;
		status_t                 status;
	} deque_result_t;

	logic                    clk    = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start  = 1'b0;
	logic [KIND_W-1:0]       kind   = '0;
	logic signed [VAL_W-1:0] value  = '0;
	logic [IDX_W-1:0]        index  = '0;
	logic                    busy;
	logic                    done;
	logic signed [VAL_W-1:0] read_value;
	logic [OCNT_W-1:0]       count;
	logic [1:0]              status;

	// deque model state
	logic [VAL_W-1:0] ring_mem [DEPTH];
	int unsigned      ring_head  = 0;
	int unsigned      ring_tail  = 0;
	int unsigned      ring_count = 0;

	deque_result_t expected_results[$];
	int            fail_count  = 0;
	int            idle_cycles = 0;
	bit            no_gaps     = 1'b0;

	always #1 clk = ~clk;

	circular_deque_buffer_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.value      (value),
		.index      (index),
		.done       (done),
		.read_value (read_value),
		.count      (count),
		.status     (status)
	);

	function automatic deque_result_t apply_deque_op(logic [KIND_W-1:0] op,
			logic [VAL_W-1:0] data, logic [IDX_W-1:0] offset);
		deque_result_t res;
		res.read_value = '0;
		res.status     = ST_OK;
		case (op)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (ring_count >= DEPTH) begin
					res.status = ST_FULL;
				end else if (op == OP_PUSH_BACK) begin
					ring_mem[ring_tail] = data;
					ring_tail = (ring_tail + 1) % DEPTH;
					ring_count++;
				end else begin
					ring_head = (ring_head + DEPTH - 1) % DEPTH;
					ring_mem[ring_head] = data;
					ring_count++;
				end
			end
			OP_POP_BACK, OP_POP_FRONT: begin
				if (ring_count == 0) begin
					res.status = ST_EMPTY;
				end else if (op == OP_POP_BACK) begin
					ring_tail = (ring_tail + DEPTH - 1) % DEPTH;
					ring_count--;
				end else begin
					ring_head = (ring_head + 1) % DEPTH;
					ring_count--;
				end
			end
			OP_CLEAR: begin
				ring_head  = 0;
				ring_tail  = 0;
				ring_count = 0;
			end
			OP_READ: begin
				if (offset >= ring_count)
					res.status = ST_RANGE;
				else
					res.read_value = ring_mem[(ring_head + offset) % DEPTH];
			end
			default: ;
		endcase
		res.count = ring_count[OCNT_W-1:0];
		return res;
	endfunction

	// mostly back to back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_op(input logic [KIND_W-1:0] op, input logic [VAL_W-1:0] data,
			input logic [IDX_W-1:0] offset);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= op;
		value <= data;
		index <= offset;
		do @(posedge clk); while (busy);
		expected_results.insert(expected_results.size(), apply_deque_op(op, data, offset));
	endtask

	task automatic test_empty_queue();
		send_op(OP_POP_BACK, '0, '0);
		send_op(OP_POP_FRONT, VAL_W'($urandom), '0);
		send_op(OP_READ, '0, '0);
		send_op(OP_READ, '0, '1);
		send_op(OP_SPARE_LO, VAL_W'($urandom), IDX_W'($urandom));
		send_op(OP_SPARE_HI, '1, '1);
		send_op(OP_CLEAR, '0, '0);
	endtask

	task automatic test_extremes();
		int i;
		send_op(OP_PUSH_BACK, 32'h7FFF_FFFF, '0);
		send_op(OP_PUSH_BACK, 32'h8000_0000, '0);
		send_op(OP_PUSH_FRONT, 32'h0000_0000, '1);
		send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF, '0);
		for (i = 0; i < 5; i++)
			send_op(OP_READ, VAL_W'($urandom), IDX_W'(i));
		send_op(OP_READ, '0, '1);
		send_op(OP_SPARE_HI, VAL_W'($urandom), IDX_W'($urandom));
		send_op(OP_POP_BACK, '0, '0);
		send_op(OP_POP_FRONT, '0, '0);
		send_op(OP_READ, '0, 10'd1);
		send_op(OP_CLEAR, '0, '0);
		send_op(OP_READ, '0, '0);
	endtask

	// fill to capacity from both ends (the head wraps), push into a full queue, then pop, push and read
	task automatic test_full_wrap();
		int i;
		send_op(OP_CLEAR, '0, '0);
		for (i = 0; i < DEPTH; i++)
			send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
				VAL_W'($urandom), '0);
		send_op(OP_PUSH_BACK, VAL_W'($urandom), '0);
		send_op(OP_PUSH_FRONT, VAL_W'($urandom), '0);
		send_op(OP_READ, '0, '0);
		send_op(OP_READ, '0, '1);
		send_op(OP_READ, '0, IDX_W'($urandom));
		for (i = 0; i < 40; i++)
			send_op(OP_POP_FRONT, '0, '0);
		for (i = 0; i < 30; i++)
			send_op(OP_PUSH_BACK, VAL_W'($urandom), '0);
		for (i = 0; i < 20; i++)
			send_op(OP_POP_BACK, '0, '0);
		for (i = 0; i < 10; i++)
			send_op(OP_READ, '0, IDX_W'($urandom_range(0, ring_count - 1)));
		send_op(OP_READ, '0, '1);
		send_op(OP_CLEAR, '0, '0);
	endtask

	task automatic test_random_mix();
		int i;
		int mode;
		int r;
		int push_pct;
		int pop_pct;
		logic [IDX_W-1:0] offset;
		mode = 0;
		for (i = 0; i < RANDOM_OPS; i++) begin
			if (i % 32 == 0) begin
				mode    = $urandom_range(0, 2);
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			push_pct = (mode == 0) ? 60 : (mode == 1) ? 15 : 35;
			pop_pct  = (mode == 0) ? 10 : (mode == 1) ? 55 : 30;
			r = $urandom_range(0, 99);
			if (r < push_pct) begin
				send_op($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
					VAL_W'($urandom), IDX_W'($urandom));
			end else if (r < push_pct + pop_pct) begin
				send_op($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT,
					VAL_W'($urandom), IDX_W'($urandom));
			end else if (r < 96) begin
				r = $urandom_range(0, 99);
				if (r < 70 && ring_count > 0)
					offset = IDX_W'($urandom_range(0, ring_count - 1));
				else if (r < 85)
					offset = ring_count[IDX_W-1:0];
				else
					offset = IDX_W'($urandom);
				send_op(OP_READ, VAL_W'($urandom), offset);
			end else if (r < 97) begin
				send_op(OP_CLEAR, VAL_W'($urandom), IDX_W'($urandom));
			end else begin
				send_op($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI,
					VAL_W'($urandom), IDX_W'($urandom));
			end
		end
		no_gaps = 1'b0;
	endtask

	// check each done beat against the oldest prediction
	always @(posedge clk) begin
		deque_result_t exp_res;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("unexpected result: rv=%h cnt=%0d st=%0d",
						read_value, count, status);
			end else begin
				exp_res = expected_results[0];
				expected_results.delete(0);
				if (read_value !== exp_res.read_value || count !== exp_res.count ||
						status !== exp_res.status) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("mismatch: expected rv=%h cnt=%0d st=%0d, got rv=%h cnt=%0d st=%0d",
							exp_res.read_value, exp_res.count, exp_res.status,
							read_value, count, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_extremes();
		test_full_wrap();
		test_random_mix();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
